// ----- hw/rtl/afm_pkg.sv -----
// ---------------------------------------------------------------------------
// afm_pkg
// Shared types and constants of the adaptive frequency model: field widths,
// operation and register codes, increment constants and the sequencer states.
// ---------------------------------------------------------------------------
package afm_pkg;

  // fixed field widths of the stream and configuration beats
  localparam int SYM_W  = 7;
  localparam int BYTE_W = 32;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 16;
  localparam int WSH_W  = 2;
  localparam int STEP_W = 3;

  // operation codes
  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  // configuration register indexes
  localparam logic CFG_WINDOW_SHIFT = 1'b0;
  localparam logic CFG_MAX_TOTAL    = 1'b1;

  // configuration reset values
  localparam logic [WSH_W-1:0] WINDOW_SHIFT_RST = 2'd0;
  localparam logic [CNT_W-1:0] MAX_TOTAL_RST    = 16'd16383;

  // increment selection
  localparam logic [BYTE_W-1:0] BYTE_LIMIT = 32'd20000;
  localparam logic [STEP_W-1:0] STEP_SMALL = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LARGE = 3'd5;

  typedef struct packed {
    logic              op;
    logic [SYM_W-1:0]  sym;
    logic [BYTE_W-1:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] cum_low;
    logic [CNT_W-1:0] cum_high;
    logic [CNT_W-1:0] total;
  } res_t;

  typedef struct packed {
    logic [WSH_W-1:0] window_shift;
    logic [CNT_W-1:0] max_total;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_HALVE,
    S_SRCH0,
    S_SRCH,
    S_SWAP_RD,
    S_SWAP_WR1,
    S_SWAP_WR2,
    S_CUM,
    S_DONE
  } state_e;

endpackage

// ----- hw/rtl/afm_ram.sv -----
// ---------------------------------------------------------------------------
// afm_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module afm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/afm_core.sv -----
// ---------------------------------------------------------------------------
// afm_core
// Sequencer and shared datapath of the frequency model: walks the count,
// cumulative and translation tables one entry per cycle for rescaling,
// equal-frequency search, swap and cumulative update.
// ---------------------------------------------------------------------------
module afm_core #(
  parameter int SYMBOL_COUNT = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  afm_pkg::cfg_t cfg_i,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  afm_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output afm_pkg::res_t res_o
);

  localparam int DEPTH = SYMBOL_COUNT + 1;
  localparam int IW    = $clog2(DEPTH);
  localparam int PW    = $clog2(SYMBOL_COUNT);
  localparam int CMP_W = (IW > afm_pkg::SYM_W) ? IW : afm_pkg::SYM_W;
  localparam logic [IW-1:0] FULL_SIZE = IW'(SYMBOL_COUNT);
  localparam logic [IW-1:0] ONE       = IW'(1);

  afm_pkg::state_e state_q, state_d;

  // control state
  logic [IW-1:0]    ms_q;
  logic [DEPTH-1:0] cum_vld_q, frq_vld_q, i2p_vld_q;

  // payload state
  logic [IW-1:0]               sym_q, idx_q, tgt_q;
  logic [afm_pkg::STEP_W-1:0]  step_q;
  logic [PW-1:0]               pos_sym_q, pos_low_q;
  logic [afm_pkg::CNT_W-1:0]   tot_q, cum_lo_q, cum_hi_q, fs_q, run_q;
  logic [IW-1:0]               cum_ra_q, frq_ra_q, i2p_ra_q;

  // table ports
  logic                      cum_we, frq_we, i2p_we;
  logic [IW-1:0]             cum_waddr, frq_waddr, i2p_waddr;
  logic [IW-1:0]             cum_raddr, frq_raddr, i2p_raddr;
  logic [afm_pkg::CNT_W-1:0] cum_wdata, frq_wdata, cum_rdata, frq_rdata;
  logic [PW-1:0]             i2p_wdata, i2p_rdata;

  // read views with never-written entries replaced by their restart value
  logic [afm_pkg::CNT_W-1:0] cum_view, frq_view, cum_rst, frq_rst;
  logic [PW-1:0]             i2p_view, i2p_rst;

  logic                      accept, restart, out_of_range, need_halve;
  logic [afm_pkg::CNT_W-1:0] f_half;

  afm_ram #(.WIDTH(afm_pkg::CNT_W), .DEPTH(DEPTH)) u_cum_ram (
    .clk_i  (clk_i),
    .we_i   (cum_we),
    .waddr_i(cum_waddr),
    .wdata_i(cum_wdata),
    .raddr_i(cum_raddr),
    .rdata_o(cum_rdata)
  );

  afm_ram #(.WIDTH(afm_pkg::CNT_W), .DEPTH(DEPTH)) u_frq_ram (
    .clk_i  (clk_i),
    .we_i   (frq_we),
    .waddr_i(frq_waddr),
    .wdata_i(frq_wdata),
    .raddr_i(frq_raddr),
    .rdata_o(frq_rdata)
  );

  afm_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_i2p_ram (
    .clk_i  (clk_i),
    .we_i   (i2p_we),
    .waddr_i(i2p_waddr),
    .wdata_i(i2p_wdata),
    .raddr_i(i2p_raddr),
    .rdata_o(i2p_rdata)
  );

  // item decode
  assign accept       = (state_q == afm_pkg::S_IDLE) && req_valid_i;
  assign restart      = accept && (req_i.op == afm_pkg::OP_RESTART);
  assign out_of_range = (CMP_W'(req_i.sym) == '0) || (CMP_W'(req_i.sym) > CMP_W'(ms_q));

  // restart values of the tables
  assign cum_rst = (cum_ra_q <= ms_q) ? afm_pkg::CNT_W'(ms_q - cum_ra_q) : '0;
  assign frq_rst = (frq_ra_q == '0) ? '0 : afm_pkg::CNT_W'(1);
  assign i2p_rst = (i2p_ra_q == '0) ? '0 : PW'(i2p_ra_q - ONE);

  assign cum_view = cum_vld_q[cum_ra_q] ? cum_rdata : cum_rst;
  assign frq_view = frq_vld_q[frq_ra_q] ? frq_rdata : frq_rst;
  assign i2p_view = i2p_vld_q[i2p_ra_q] ? i2p_rdata : i2p_rst;

  // shared arithmetic: total check and halving with round-up
  assign need_halve = ((afm_pkg::CNT_W + 1)'(tot_q) + (afm_pkg::CNT_W + 1)'(step_q))
                      > (afm_pkg::CNT_W + 1)'(cfg_i.max_total);
  assign f_half     = afm_pkg::CNT_W'(((afm_pkg::CNT_W + 1)'(frq_view) + 1'b1) >> 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      afm_pkg::S_IDLE: begin
        if (req_valid_i) begin
          if (req_i.op == afm_pkg::OP_RESTART || out_of_range) begin
            state_d = afm_pkg::S_DONE;
          end else begin
            state_d = afm_pkg::S_RD0;
          end
        end
      end
      afm_pkg::S_RD0:      state_d = afm_pkg::S_RD1;
      afm_pkg::S_RD1:      state_d = afm_pkg::S_RD2;
      afm_pkg::S_RD2:      state_d = afm_pkg::S_RD3;
      afm_pkg::S_RD3:      state_d = need_halve ? afm_pkg::S_HALVE : afm_pkg::S_SRCH0;
      afm_pkg::S_HALVE: begin
        if (idx_q == '0) begin
          state_d = afm_pkg::S_SRCH0;
        end
      end
      afm_pkg::S_SRCH0:    state_d = (sym_q == ONE) ? afm_pkg::S_SWAP_RD : afm_pkg::S_SRCH;
      afm_pkg::S_SRCH: begin
        if (frq_view != fs_q || idx_q == ONE) begin
          state_d = afm_pkg::S_SWAP_RD;
        end
      end
      afm_pkg::S_SWAP_RD:  state_d = afm_pkg::S_SWAP_WR1;
      afm_pkg::S_SWAP_WR1: state_d = afm_pkg::S_SWAP_WR2;
      afm_pkg::S_SWAP_WR2: state_d = afm_pkg::S_CUM;
      afm_pkg::S_CUM: begin
        if (idx_q == '0) begin
          state_d = afm_pkg::S_DONE;
        end
      end
      afm_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = afm_pkg::S_IDLE;
        end
      end
      default:             state_d = afm_pkg::S_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    cum_we    = 1'b0;
    frq_we    = 1'b0;
    i2p_we    = 1'b0;
    cum_waddr = '0;
    frq_waddr = '0;
    i2p_waddr = '0;
    cum_wdata = '0;
    frq_wdata = '0;
    i2p_wdata = '0;
    cum_raddr = '0;
    frq_raddr = '0;
    i2p_raddr = '0;
    case (state_q)
      afm_pkg::S_RD0: begin
        i2p_raddr = sym_q;
      end
      afm_pkg::S_RD1: begin
        cum_raddr = sym_q;
      end
      afm_pkg::S_RD2: begin
        cum_raddr = sym_q - ONE;
      end
      afm_pkg::S_RD3: begin
        frq_raddr = need_halve ? ms_q : sym_q;
      end
      afm_pkg::S_HALVE: begin
        frq_we    = 1'b1;
        frq_waddr = idx_q;
        frq_wdata = f_half;
        cum_we    = 1'b1;
        cum_waddr = idx_q;
        cum_wdata = run_q;
        frq_raddr = (idx_q == '0) ? sym_q : idx_q - ONE;
      end
      afm_pkg::S_SRCH0: begin
        frq_raddr = sym_q - ONE;
      end
      afm_pkg::S_SRCH: begin
        frq_raddr = idx_q - ONE;
      end
      afm_pkg::S_SWAP_RD: begin
        i2p_raddr = tgt_q;
      end
      afm_pkg::S_SWAP_WR1: begin
        i2p_we    = 1'b1;
        i2p_waddr = tgt_q;
        i2p_wdata = pos_sym_q;
        frq_we    = 1'b1;
        frq_waddr = tgt_q;
        frq_wdata = afm_pkg::CNT_W'(fs_q + afm_pkg::CNT_W'(step_q));
      end
      afm_pkg::S_SWAP_WR2: begin
        i2p_we    = 1'b1;
        i2p_waddr = sym_q;
        i2p_wdata = pos_low_q;
        cum_raddr = tgt_q - ONE;
      end
      afm_pkg::S_CUM: begin
        cum_we    = 1'b1;
        cum_waddr = idx_q;
        cum_wdata = afm_pkg::CNT_W'(cum_view + afm_pkg::CNT_W'(step_q));
        cum_raddr = (idx_q == '0) ? '0 : idx_q - ONE;
      end
      default: begin
      end
    endcase
  end

  // sequencer state, model size and written-entry flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= afm_pkg::S_IDLE;
      ms_q      <= FULL_SIZE;
      cum_vld_q <= '0;
      frq_vld_q <= '0;
      i2p_vld_q <= '0;
    end else begin
      state_q <= state_d;
      if (restart) begin
        ms_q      <= FULL_SIZE >> cfg_i.window_shift;
        cum_vld_q <= '0;
        frq_vld_q <= '0;
        i2p_vld_q <= '0;
      end else begin
        if (cum_we) begin
          cum_vld_q[cum_waddr] <= 1'b1;
        end
        if (frq_we) begin
          frq_vld_q[frq_waddr] <= 1'b1;
        end
        if (i2p_we) begin
          i2p_vld_q[i2p_waddr] <= 1'b1;
        end
      end
    end
  end

  // read address tracking for the restart-value views
  always_ff @(posedge clk_i) begin
    cum_ra_q <= cum_raddr;
    frq_ra_q <= frq_raddr;
    i2p_ra_q <= i2p_raddr;
  end

  // walk registers and captured result fields
  always_ff @(posedge clk_i) begin
    case (state_q)
      afm_pkg::S_IDLE: begin
        if (req_valid_i) begin
          sym_q  <= IW'(req_i.sym);
          step_q <= (req_i.byte_count < afm_pkg::BYTE_LIMIT) ? afm_pkg::STEP_SMALL
                                                             : afm_pkg::STEP_LARGE;
          if (req_i.op == afm_pkg::OP_RESTART || out_of_range) begin
            pos_sym_q <= '0;
            tot_q     <= '0;
            cum_lo_q  <= '0;
            cum_hi_q  <= '0;
          end
        end
      end
      afm_pkg::S_RD1: begin
        tot_q     <= cum_view;
        pos_sym_q <= i2p_view;
      end
      afm_pkg::S_RD2: begin
        cum_lo_q <= cum_view;
      end
      afm_pkg::S_RD3: begin
        cum_hi_q <= cum_view;
        idx_q    <= ms_q;
        run_q    <= '0;
      end
      afm_pkg::S_HALVE: begin
        run_q <= run_q + f_half;
        idx_q <= idx_q - ONE;
      end
      afm_pkg::S_SRCH0: begin
        fs_q  <= frq_view;
        tgt_q <= sym_q;
        idx_q <= sym_q - ONE;
      end
      afm_pkg::S_SRCH: begin
        if (frq_view == fs_q) begin
          tgt_q <= idx_q;
        end
        idx_q <= idx_q - ONE;
      end
      afm_pkg::S_SWAP_WR1: begin
        pos_low_q <= i2p_view;
      end
      afm_pkg::S_SWAP_WR2: begin
        idx_q <= tgt_q - ONE;
      end
      afm_pkg::S_CUM: begin
        idx_q <= idx_q - ONE;
      end
      default: begin
      end
    endcase
  end

  // handshake and result
  assign req_ready_o     = (state_q == afm_pkg::S_IDLE);
  assign res_valid_o     = (state_q == afm_pkg::S_DONE);
  assign res_o.position  = afm_pkg::POS_W'(pos_sym_q);
  assign res_o.cum_low   = cum_lo_q;
  assign res_o.cum_high  = cum_hi_q;
  assign res_o.total     = tot_q;

endmodule

// ----- hw/rtl/adaptive_frequency_model.sv -----
// ---------------------------------------------------------------------------
// adaptive_frequency_model
// Frequency-sorted adaptive model for an arithmetic coder, with stream ports
// and a plain configuration write port.
// ---------------------------------------------------------------------------
// One item is taken at a time. A restart, or an update whose symbol index is
// zero or above the model size, returns an all-zero beat. An update halves
// the counts first when the total would exceed max_total; each table has one
// read port, so the halving pass, the equal-frequency search and the
// cumulative update each visit one entry per cycle. The result beat sits in
// an output register, so the next item may be offered while it waits. The
// tables hold no reset pass: restart and reset take effect at once.
module adaptive_frequency_model #(
  parameter int SYMBOL_COUNT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // symbol_index[6:0], byte_count[38:7], zero pad
  input  logic        s_axis_tuser,  // operation
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // position[5:0], cum_low[21:6], cum_high[37:22],
                                     // total[53:38], zero pad
);

  afm_pkg::cfg_t cfg_q;
  afm_pkg::req_t req;
  afm_pkg::res_t res, out_q;
  logic          res_valid, res_ready, out_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_shift <= afm_pkg::WINDOW_SHIFT_RST;
      cfg_q.max_total    <= afm_pkg::MAX_TOTAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        afm_pkg::CFG_WINDOW_SHIFT: cfg_q.window_shift <= cfg_wdata_i[afm_pkg::WSH_W-1:0];
        afm_pkg::CFG_MAX_TOTAL:    cfg_q.max_total    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // input beat unpacking
  assign req.op         = s_axis_tuser;
  assign req.sym        = s_axis_tdata[6:0];
  assign req.byte_count = s_axis_tdata[38:7];

  afm_core #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.total, out_q.cum_high, out_q.cum_low, out_q.position};

endmodule
